>>> src/cpa_pkg.sv
package cpa_pkg;

  localparam int IN_W             = 24;
  localparam int VAL_W            = 25;
  localparam int PROD_W           = 2 * VAL_W;
  localparam int SQ_W             = 49;
  localparam int SUM_W            = 29;
  localparam int POW_W            = 55;
  localparam int MEAN_SHIFT       = 4;
  localparam int MEAN_W           = SUM_W - MEAN_SHIFT;
  localparam int POW_OUT_W        = POW_W - MEAN_SHIFT;
  localparam int DEF_SLICES       = 16;
  localparam int DEF_SAMPLE_WIDTH = 24;
  localparam int QUEUE_DEPTH      = 4;

  typedef struct packed {
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
    logic                    last;
  } item_t;

endpackage

>>> src/complex_power_average_unit.sv
// Throughput: one input transfer per cycle while in_stall stays low; one result per SLICES inputs.
// The front register, a 4-entry queue, a squaring stage and the output register lie between input and result.
// Reset clears the slice count, the accumulators, the queue and all valid flags.
module complex_power_average_unit #(
  parameter int SLICES       = cpa_pkg::DEF_SLICES,
  parameter int SAMPLE_WIDTH = cpa_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cpa_pkg::IN_W-1:0]          real_real,
  input  logic [cpa_pkg::IN_W-1:0]          imag_imag,
  input  logic [cpa_pkg::IN_W-1:0]          real_imag,
  input  logic [cpa_pkg::IN_W-1:0]          imag_real,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cpa_pkg::MEAN_W-1:0] mean_real,
  output logic signed [cpa_pkg::MEAN_W-1:0] mean_imag,
  output logic [cpa_pkg::POW_OUT_W-1:0]     mean_power
);
  import cpa_pkg::*;

  logic  item_valid;
  item_t item;
  logic  queue_full;
  logic  queue_not_empty;
  logic  pop;
  item_t head;

  cpa_front #(
    .SLICES       (SLICES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .real_real  (real_real),
    .imag_imag  (imag_imag),
    .real_imag  (real_imag),
    .imag_real  (imag_real),
    .queue_full (queue_full),
    .item_valid (item_valid),
    .item       (item)
  );

  cpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid && !queue_full),
    .push_item (item),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head)
  );

  cpa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (queue_not_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mean_real  (mean_real),
    .mean_imag  (mean_imag),
    .mean_power (mean_power)
  );

endmodule

>>> src/cpa_front.sv
module cpa_front #(
  parameter int SLICES       = cpa_pkg::DEF_SLICES,
  parameter int SAMPLE_WIDTH = cpa_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cpa_pkg::IN_W-1:0]   real_real,
  input  logic [cpa_pkg::IN_W-1:0]   imag_imag,
  input  logic [cpa_pkg::IN_W-1:0]   real_imag,
  input  logic [cpa_pkg::IN_W-1:0]   imag_real,
  input  logic                       queue_full,
  output logic                       item_valid,
  output cpa_pkg::item_t             item
);
  import cpa_pkg::*;

  localparam int CNT_W     = $clog2(SLICES);
  localparam int EXT_SHIFT = IN_W - SAMPLE_WIDTH;

  logic [CNT_W-1:0]        slice_count;
  logic                    load;
  logic                    push;
  logic                    last;
  logic signed [VAL_W-1:0] re;
  logic signed [VAL_W-1:0] im;

  function automatic logic signed [VAL_W-1:0] extend(input logic [IN_W-1:0] raw);
    logic signed [IN_W-1:0] t;
    t = raw << EXT_SHIFT;
    t = t >>> EXT_SHIFT;
    return {t[IN_W-1], t};
  endfunction

  assign push     = item_valid && !queue_full;
  assign in_stall = item_valid && queue_full;
  assign load     = in_valid && !in_stall;
  assign last     = (slice_count == CNT_W'(SLICES - 1));
  assign re       = extend(real_real) + extend(imag_imag);
  assign im       = extend(real_imag) - extend(imag_real);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid  <= 1'b0;
      slice_count <= '0;
    end else begin
      if (load) begin
        item_valid  <= 1'b1;
        slice_count <= last ? '0 : slice_count + 1'b1;
      end else if (push) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.re   <= re;
      item.im   <= im;
      item.last <= last;
    end
  end

endmodule

>>> src/cpa_queue.sv
module cpa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cpa_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output cpa_pkg::item_t head
);
  import cpa_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = (fill == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> src/cpa_back.sv
module cpa_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              not_empty,
  input  cpa_pkg::item_t                    head,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cpa_pkg::MEAN_W-1:0] mean_real,
  output logic signed [cpa_pkg::MEAN_W-1:0] mean_imag,
  output logic [cpa_pkg::POW_OUT_W-1:0]     mean_power
);
  import cpa_pkg::*;

  logic                    a_valid;
  logic signed [VAL_W-1:0] a_re;
  logic signed [VAL_W-1:0] a_im;
  logic                    a_last;
  logic [SQ_W-1:0]         a_sq_re;
  logic [SQ_W-1:0]         a_sq_im;

  logic signed [SUM_W-1:0] sum_real;
  logic signed [SUM_W-1:0] sum_imag;
  logic [POW_W-1:0]        sum_power;
  logic signed [SUM_W-1:0] sum_real_next;
  logic signed [SUM_W-1:0] sum_imag_next;
  logic [POW_W-1:0]        sum_power_next;

  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic                     out_free;
  logic                     a_adv;
  logic                     emit;

  assign prod_re  = head.re * head.re;
  assign prod_im  = head.im * head.im;
  assign out_free = !out_valid || !out_stall;
  assign a_adv    = a_valid && (!a_last || out_free);
  assign emit     = a_adv && a_last;
  assign pop      = not_empty && (!a_valid || a_adv);

  assign sum_real_next  = sum_real + {{(SUM_W - VAL_W){a_re[VAL_W-1]}}, a_re};
  assign sum_imag_next  = sum_imag + {{(SUM_W - VAL_W){a_im[VAL_W-1]}}, a_im};
  assign sum_power_next = sum_power + POW_W'(a_sq_re) + POW_W'(a_sq_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      sum_real  <= '0;
      sum_imag  <= '0;
      sum_power <= '0;
    end else begin
      if (pop) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        if (a_last) begin
          sum_real  <= '0;
          sum_imag  <= '0;
          sum_power <= '0;
        end else begin
          sum_real  <= sum_real_next;
          sum_imag  <= sum_imag_next;
          sum_power <= sum_power_next;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_re    <= head.re;
      a_im    <= head.im;
      a_last  <= head.last;
      a_sq_re <= prod_re[SQ_W-1:0];
      a_sq_im <= prod_im[SQ_W-1:0];
    end
    if (emit) begin
      mean_real  <= sum_real_next[SUM_W-1:MEAN_SHIFT];
      mean_imag  <= sum_imag_next[SUM_W-1:MEAN_SHIFT];
      mean_power <= sum_power_next[POW_W-1:MEAN_SHIFT];
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cpa_pkg::*;

  localparam int SLICE_N  = DEF_SLICES;
  localparam int SAMPLE_W = DEF_SAMPLE_WIDTH;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [MEAN_W-1:0] re;
    logic signed [MEAN_W-1:0] im;
    logic [POW_OUT_W-1:0]     pw;
  } mean_t;

  typedef struct {
    int               count;
    logic [IN_W-1:0]  rr;
    logic [IN_W-1:0]  ii;
    logic [IN_W-1:0]  ri;
    logic [IN_W-1:0]  ir;
    bit               typed;
    mean_t            want;
  } plan_row_t;

  typedef enum int {MIX_FULL, MIX_EXTREME, MIX_SMALL} mix_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [IN_W-1:0]          real_real = '0;
  logic [IN_W-1:0]          imag_imag = '0;
  logic [IN_W-1:0]          real_imag = '0;
  logic [IN_W-1:0]          imag_real = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [MEAN_W-1:0] mean_real;
  logic signed [MEAN_W-1:0] mean_imag;
  logic [POW_OUT_W-1:0]     mean_power;

  mean_t             mean_q[$];
  int                errors = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_req = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  int                acc_count = 0;
  longint            acc_real = 0;
  longint            acc_imag = 0;
  longint unsigned   acc_power = 0;

  complex_power_average_unit #(
    .SLICES      (SLICE_N),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .real_real (real_real),
    .imag_imag (imag_imag),
    .real_imag (real_imag),
    .imag_real (imag_real),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mean_real (mean_real),
    .mean_imag (mean_imag),
    .mean_power(mean_power)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic longint widen(input logic [IN_W-1:0] raw);
    logic [63:0] v;
    v = 64'(raw) << (64 - SAMPLE_W);
    return $signed(v) >>> (64 - SAMPLE_W);
  endfunction

  function automatic bit accumulate_slice(input logic [IN_W-1:0] rr, ii, ri, ir,
                                          output mean_t m);
    longint          re;
    longint          im;
    longint unsigned re_mag;
    longint unsigned im_mag;
    re = widen(rr) + widen(ii);
    im = widen(ri) - widen(ir);
    re_mag = (re < 0) ? -re : re;
    im_mag = (im < 0) ? -im : im;
    acc_real += re;
    acc_imag += im;
    acc_power += re_mag * re_mag + im_mag * im_mag;
    acc_count++;
    m = '0;
    if (acc_count < SLICE_N) return 1'b0;
    m.re = MEAN_W'(acc_real >>> MEAN_SHIFT);
    m.im = MEAN_W'(acc_imag >>> MEAN_SHIFT);
    m.pw = POW_OUT_W'(acc_power >> MEAN_SHIFT);
    acc_count = 0;
    acc_real = 0;
    acc_imag = 0;
    acc_power = 0;
    return 1'b1;
  endfunction

  function automatic logic [IN_W-1:0] pick_sample(input mix_t mix);
    logic [IN_W-1:0] v;
    v = IN_W'($urandom);
    case (mix)
      MIX_EXTREME: begin
        case ($urandom_range(3))
          0: v = {1'b1, {(IN_W-1){1'b0}}};
          1: v = {1'b0, {(IN_W-1){1'b1}}};
          2: v = '1;
          default: ;
        endcase
      end
      MIX_SMALL: v = {{(IN_W-4){v[3]}}, v[3:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_slice(input logic [IN_W-1:0] rr, ii, ri, ir,
                            input bit typed, input mean_t want);
    mean_t m;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    real_real <= rr;
    imag_imag <= ii;
    real_imag <= ri;
    imag_real <= ir;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (accumulate_slice(rr, ii, ri, ir, m)) mean_q.push_back(typed ? want : m);
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    mean_t want;
    if (!rst && out_valid && !out_stall) begin
      if (mean_q.size() == 0) begin
        flag_mismatch("result transfer with no expectation pending");
      end else begin
        want = mean_q.pop_front();
        if (mean_real !== want.re)
          flag_mismatch($sformatf("mean_real %0d, expected %0d", mean_real, want.re));
        if (mean_imag !== want.im)
          flag_mismatch($sformatf("mean_imag %0d, expected %0d", mean_imag, want.im));
        if (mean_power !== want.pw)
          flag_mismatch($sformatf("mean_power %0d, expected %0d", mean_power, want.pw));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    plan_row_t plan[4];
    mix_t      mix;
    int        wait_cnt;
    int        idle_plan[3][2];

    plan[0] = '{8, 24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 1'b0, '0};
    plan[1] = '{8, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b0, '0};
    plan[2] = '{1, 24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 1'b0, '0};
    plan[3] = '{15, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1,
                '{MEAN_W'(-1), MEAN_W'(0), POW_OUT_W'(0)}};
    idle_plan = '{'{26, 86}, '{86, 26}, '{0, 0}};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].count; k++) begin
        send_slice(plan[r].rr, plan[r].ii, plan[r].ri, plan[r].ir,
                   plan[r].typed && (k == plan[r].count - 1), plan[r].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = idle_plan[ph][0];
      recv_idle_pct = idle_plan[ph][1];
      if (ph == 2) hold_req++;
      for (int g = 0; g < 40; g++) begin
        mix = mix_t'($urandom_range(2));
        for (int s = 0; s < SLICE_N; s++) begin
          send_slice(pick_sample(mix), pick_sample(mix), pick_sample(mix),
                     pick_sample(mix), 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (mean_q.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (10) @(posedge clk);
    if (mean_q.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", mean_q.size()));

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
src/cpa_pkg.sv
src/cpa_front.sv
src/cpa_queue.sv
src/cpa_back.sv
src/complex_power_average_unit.sv
tb/tb_top.sv
